/* rtl/mfb_pkg.sv */
// Shared types and constants of the max-flow block.
// No dependencies; used by mfb_alu, max_flow_bfs_augment and tb_top.
package mfb_pkg;

  localparam int CELL_W = 40;
  localparam int FLOW_W = 48;
  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  // register word indexes (paddr[3:2])
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_SINK       = 2'd2;

  typedef enum logic [1:0] {
    ALU_CELL_ADD,
    ALU_SUB,
    ALU_FLOW_ADD,
    ALU_MIN
  } alu_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_BFS_INIT,
    S_DEQ,
    S_DEQ_WAIT,
    S_SCAN,
    S_NK_PAR,
    S_NK_ADDR,
    S_NK_MIN,
    S_AG_PAR,
    S_AG_ADDR,
    S_AG_FWD,
    S_AG_REV,
    S_FLOW,
    S_OUT
  } state_t;

endpackage

/* rtl/mfb_alu.sv */
// Shared arithmetic unit: saturating adds, subtract and minimum.
// Depends on mfb_pkg.
module mfb_alu
  import mfb_pkg::*;
(
  input  alu_op_t           op,
  input  logic [FLOW_W-1:0] a,
  input  logic [FLOW_W-1:0] b,
  output logic [FLOW_W-1:0] y
);

  logic [FLOW_W:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (op)
      ALU_CELL_ADD: begin
        // saturate at the cell width
        if (sum > {{(FLOW_W-CELL_W+1){1'b0}}, CELL_MAX}) y = {{(FLOW_W-CELL_W){1'b0}}, CELL_MAX};
        else y = sum[FLOW_W-1:0];
      end
      ALU_SUB:      y = a - b;
      ALU_FLOW_ADD: y = sum[FLOW_W] ? FLOW_MAX : sum[FLOW_W-1:0];
      ALU_MIN:      y = (a < b) ? a : b;
      default:      y = '0;
    endcase
  end

endmodule

/* rtl/max_flow_bfs_augment.sv */
// Top level of the max-flow block: edge loading, BFS augment sequencer, APB registers.
// Depends on mfb_pkg and mfb_alu.
//
// Usage: write node_count (0x0), source_node (0x4) and sink_node (0x8) over APB
// while busy is low. Edges enter on start when busy is low; each edge has its
// cell read at the accepting edge, then is added and written back in the load
// state, and the next edge is taken only once the block is back in idle.
// An edge with last_edge set starts the solve. Each BFS pass has an init step,
// a dequeue and a wait step per dequeued node and a scan step per neighbor;
// the bottleneck walk has a parent, an address and a minimum step per path hop,
// the update a parent, an address, a forward and a reverse step per hop.
// done is high for one cycle while max_flow holds the total; the receiver
// cannot stall it. Afterwards all DEPTH cells of the matrix (16384 by default)
// are cleared, one cell per cycle. The same clearing pass runs after reset;
// busy stays high throughout.
module max_flow_bfs_augment
  import mfb_pkg::*;
#(
  parameter int MAX_NODES = 128,
  parameter int CAP_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [6:0]  from_node,
  input  logic [6:0]  to_node,
  input  logic [31:0] capacity,
  input  logic        last_edge,
  output logic        done,
  output logic [47:0] max_flow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int NP    = 1 << NW;
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;
  localparam logic [8:0] NMAX = 9'(MAX_NODES);
  localparam logic [CELL_W-1:0] CAP_MASK = CELL_W'((41'(1) << CAP_BITS) - 41'(1));

  // configuration registers
  logic [7:0] node_count;
  logic [6:0] source_node;
  logic [6:0] sink_node;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= 8'd128;
      source_node <= 7'd0;
      sink_node   <= 7'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NODE_COUNT: node_count  <= pwdata[7:0];
        REG_SOURCE:     source_node <= pwdata[6:0];
        REG_SINK:       sink_node   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NODE_COUNT: prdata = {24'd0, node_count};
      REG_SOURCE:     prdata = {25'd0, source_node};
      REG_SINK:       prdata = {25'd0, sink_node};
      default:        prdata = '0;
    endcase
  end

  // effective node count, clamped to [2, MAX_NODES]
  logic [8:0] n_eff;
  always_comb begin
    n_eff = {1'b0, node_count};
    if (n_eff < 9'd2) n_eff = 9'd2;
    if (n_eff > NMAX) n_eff = NMAX;
  end

  logic [NW-1:0] src_i, snk_i;
  assign src_i = NW'(source_node);
  assign snk_i = NW'(sink_node);

  // sequencer and datapath registers
  state_t state, state_next;

  logic [NW-1:0]     ld_u, ld_v;
  logic [CELL_W-1:0] ld_cap;
  logic              ld_last, ld_ok;
  logic [NW-1:0]     u, c, p;
  logic [NW:0]       v, head, tail;
  logic [NP-1:0]     visited;
  logic [CELL_W-1:0] neck;
  logic [FLOW_W-1:0] flow_total;
  logic [AW-1:0]     clr_cnt;

  // residual matrix
  logic [CELL_W-1:0] mat [DEPTH];
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CELL_W-1:0] rd_data, wr_data;
  logic              wr_en;

  // parent and queue stores
  logic [NW-1:0] par_mem [NP];
  logic [NW-1:0] que_mem [NP];
  logic [NW-1:0] par_raddr, que_raddr, que_waddr, que_wdata;
  logic [NW-1:0] par_q, que_q;
  logic          par_we, que_we;

  // shared unit
  alu_op_t           alu_op;
  logic [FLOW_W-1:0] alu_a, alu_b, alu_y;

  mfb_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  logic hit;
  logic [NW-1:0] v_i;
  assign v_i = v[NW-1:0];
  assign hit = !visited[v_i] && (rd_data != '0);

  // next state, memory controls and shared unit operands
  always_comb begin
    state_next = state;
    rd_addr    = {u, v_i};
    wr_en      = 1'b0;
    wr_addr    = {p, c};
    wr_data    = alu_y[CELL_W-1:0];
    par_raddr  = c;
    que_raddr  = head[NW-1:0];
    par_we     = 1'b0;
    que_we     = 1'b0;
    que_waddr  = tail[NW-1:0];
    que_wdata  = v_i;
    alu_op     = ALU_CELL_ADD;
    alu_a      = {{(FLOW_W-CELL_W){1'b0}}, rd_data};
    alu_b      = {{(FLOW_W-CELL_W){1'b0}}, neck};
    done       = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (clr_cnt == {AW{1'b1}}) state_next = S_IDLE;
      end
      S_IDLE: begin
        rd_addr = {NW'(from_node), NW'(to_node)};
        if (start) state_next = S_LOAD;
      end
      S_LOAD: begin
        alu_b   = {{(FLOW_W-CELL_W){1'b0}}, ld_cap};
        wr_en   = ld_ok;
        wr_addr = {ld_u, ld_v};
        if (!ld_last) state_next = S_IDLE;
        else if (source_node == sink_node || {2'b0, source_node} >= n_eff ||
                 {2'b0, sink_node} >= n_eff) state_next = S_OUT;
        else state_next = S_BFS_INIT;
      end
      S_BFS_INIT: begin
        que_we     = 1'b1;
        que_waddr  = '0;
        que_wdata  = src_i;
        state_next = S_DEQ;
      end
      S_DEQ: begin
        if (head == tail) state_next = S_OUT;
        else state_next = S_DEQ_WAIT;
      end
      S_DEQ_WAIT: begin
        rd_addr    = {que_q, {NW{1'b0}}};
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = {u, NW'(v + 1'b1)};
        if (hit) begin
          par_we = 1'b1;
          que_we = (tail < NMAX[NW:0]);
        end
        if (hit && v_i == snk_i) state_next = S_NK_PAR;
        else if ({{(8-NW){1'b0}}, v} + 9'd1 == n_eff) state_next = S_DEQ;
      end
      S_NK_PAR: state_next = S_NK_ADDR;
      S_NK_ADDR: begin
        rd_addr    = {par_q, c};
        state_next = S_NK_MIN;
      end
      S_NK_MIN: begin
        alu_op     = ALU_MIN;
        state_next = (p == src_i) ? S_AG_PAR : S_NK_PAR;
      end
      S_AG_PAR: state_next = S_AG_ADDR;
      S_AG_ADDR: begin
        rd_addr    = {par_q, c};
        state_next = S_AG_FWD;
      end
      S_AG_FWD: begin
        alu_op     = ALU_SUB;
        wr_en      = 1'b1;
        wr_addr    = {p, c};
        rd_addr    = {c, p};
        state_next = S_AG_REV;
      end
      S_AG_REV: begin
        alu_op     = ALU_CELL_ADD;
        wr_en      = 1'b1;
        wr_addr    = {c, p};
        state_next = (p == src_i) ? S_FLOW : S_AG_PAR;
      end
      S_FLOW: begin
        alu_op     = ALU_FLOW_ADD;
        alu_a      = flow_total;
        state_next = S_BFS_INIT;
      end
      S_OUT: begin
        done       = 1'b1;
        state_next = S_CLEAR;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy     = (state != S_IDLE);
  assign max_flow = flow_total;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // control counters and marks
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      flow_total <= '0;
      visited    <= '0;
      head       <= '0;
      tail       <= '0;
    end else begin
      case (state)
        S_CLEAR:    clr_cnt <= clr_cnt + 1'b1;
        S_BFS_INIT: begin
          visited        <= '0;
          visited[src_i] <= 1'b1;
          head           <= '0;
          tail           <= (NW+1)'(1);
        end
        S_DEQ:  if (head != tail) head <= head + 1'b1;
        S_SCAN: if (hit) begin
          visited[v_i] <= 1'b1;
          if (tail < NMAX[NW:0]) tail <= tail + 1'b1;
        end
        S_FLOW: flow_total <= alu_y;
        S_OUT: begin
          flow_total <= '0;
          clr_cnt    <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ld_u    <= NW'(from_node);
        ld_v    <= NW'(to_node);
        ld_cap  <= {{(CELL_W-32){1'b0}}, capacity} & CAP_MASK;
        ld_last <= last_edge;
        ld_ok   <= ({2'b0, from_node} < n_eff) && ({2'b0, to_node} < n_eff);
      end
      S_DEQ_WAIT: begin
        u <= que_q;
        v <= '0;
      end
      S_SCAN: begin
        v <= v + 1'b1;
        if (hit && v_i == snk_i) begin
          c    <= snk_i;
          neck <= CELL_MAX;
        end
      end
      S_NK_ADDR, S_AG_ADDR: p <= par_q;
      S_NK_MIN: begin
        neck <= alu_y[CELL_W-1:0];
        c    <= (p == src_i) ? snk_i : p;
      end
      S_AG_REV: c <= p;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (wr_en) mat[wr_addr] <= wr_data;
    rd_data <= mat[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[v_i] <= u;
    par_q <= par_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (que_we) que_mem[que_waddr] <= que_wdata;
    que_q <= que_mem[que_raddr];
  end

  // checks
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_neck_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_AG_FWD) |-> (neck != '0)) else $error("zero bottleneck on augmenting path");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= NMAX[NW:0]) else $error("search queue overrun");

  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    done |=> (busy && clr_cnt == '0)) else $error("clearing pass did not follow result");

endmodule

/* sim/tb_top.sv */
// Testbench for max_flow_bfs_augment: loads directed and random edge sets, checks each max-flow total.
// Depends on mfb_pkg and the RTL top; carries its own Edmonds-Karp predictor.
`timescale 1ns / 1ps

module tb_top
  import mfb_pkg::*;
();

  localparam int NODES = 128;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [6:0]  from_node = '0;
  logic [6:0]  to_node = '0;
  logic [31:0] capacity = '0;
  logic        last_edge = 1'b0;
  logic        done;
  logic [47:0] max_flow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  max_flow_bfs_augment dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [CELL_W-1:0] cells [NODES*NODES];
  bit                seen [NODES];
  int                parent [NODES];
  int                bfs_q [NODES];
  logic [7:0]        cfg_nodes = 8'd128;
  logic [6:0]        cfg_src = 7'd0;
  logic [6:0]        cfg_snk = 7'd1;

  logic [FLOW_W-1:0] flow_q [$];
  int errors = 0;
  int edges_sent = 0;
  int totals_seen = 0;
  int idle_pct = 0;

  function automatic int eff_nodes();
    if (cfg_nodes < 2) return 2;
    if (cfg_nodes > NODES) return NODES;
    return int'(cfg_nodes);
  endfunction

  function automatic logic [CELL_W-1:0] cell_sat(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b);
    logic [CELL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
  endfunction

  // breadth-first augmenting paths until the sink is cut off
  function automatic logic [FLOW_W-1:0] solve_flow();
    int n, src, snk, head, tail, u, v, c, p;
    bit found;
    logic [CELL_W-1:0] neck;
    logic [FLOW_W:0] tot;
    n = eff_nodes();
    src = int'(cfg_src);
    snk = int'(cfg_snk);
    if (src == snk || src >= n || snk >= n) return '0;
    tot = '0;
    while (1) begin
      for (v = 0; v < NODES; v++) seen[v] = 0;
      head = 0;
      tail = 0;
      bfs_q[tail++] = src;
      seen[src] = 1;
      found = 0;
      while (head < tail && !found) begin
        u = bfs_q[head++];
        for (v = 0; v < n && !found; v++) begin
          if (!seen[v] && cells[u*NODES+v] != 0) begin
            seen[v] = 1;
            parent[v] = u;
            if (tail < NODES) bfs_q[tail++] = v;
            if (v == snk) found = 1;
          end
        end
      end
      if (!found) break;
      neck = CELL_MAX;
      for (c = snk; c != src; c = parent[c]) begin
        p = parent[c];
        if (cells[p*NODES+c] < neck) neck = cells[p*NODES+c];
      end
      for (c = snk; c != src; c = parent[c]) begin
        p = parent[c];
        cells[p*NODES+c] = cells[p*NODES+c] - neck;
        cells[c*NODES+p] = cell_sat(cells[c*NODES+p], neck);
      end
      tot = tot + {9'd0, neck};
      if (tot > {1'b0, FLOW_MAX}) tot = {1'b0, FLOW_MAX};
    end
    return tot[FLOW_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [FLOW_W-1:0] got, logic [FLOW_W-1:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // typed expectation for marked directed rows, else from the predictor
  bit               use_typed = 0;
  logic [FLOW_W-1:0] typed_flow = '0;

  // accept items, predict, and check totals
  always @(posedge clk) begin
    int n;
    logic [FLOW_W-1:0] pred;
    if (!rst) begin
      if (done) begin
        totals_seen++;
        if (flow_q.size() == 0) report_mismatch("unexpected total", max_flow, '0);
        else begin
          pred = flow_q.pop_front();
          if (max_flow !== pred) report_mismatch("max_flow", max_flow, pred);
        end
      end
      if (start && !busy) begin
        n = eff_nodes();
        if (from_node < n && to_node < n)
          cells[from_node*NODES+to_node] =
            cell_sat(cells[from_node*NODES+to_node], {8'd0, capacity});
        if (last_edge) begin
          pred = solve_flow();
          flow_q.insert(flow_q.size(), use_typed ? typed_flow : pred);
          for (int i = 0; i < NODES*NODES; i++) cells[i] = '0;
        end
      end
    end
  end

  // one edge, with an optional sender gap ahead of it
  task automatic send_edge(logic [6:0] f, logic [6:0] t, logic [31:0] c, logic l);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    from_node <= f;
    to_node <= t;
    capacity <= c;
    last_edge <= l;
    do @(posedge clk); while (busy);
    edges_sent++;
  endtask

  // hold off until every total is in and the clear pass is over
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (flow_q.size() != 0 || busy);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_NODE_COUNT: cfg_nodes = val[7:0];
      REG_SOURCE:     cfg_src = val[6:0];
      REG_SINK:       cfg_snk = val[6:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] n, logic [6:0] s, logic [6:0] k);
    drain();
    reg_write(REG_NODE_COUNT, {24'd0, n});
    reg_write(REG_SOURCE, {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, s});
    reg_write(REG_SINK, {25'd0, k});
  endtask

  // random edge set biased toward source-to-sink structure
  task automatic random_graph(int count);
    int ne;
    logic [6:0] f, t;
    logic [31:0] c;
    ne = eff_nodes();
    for (int i = 0; i < count; i++) begin
      f = ($urandom_range(99) < 10) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, ne-1));
      t = ($urandom_range(99) < 10) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, ne-1));
      if ($urandom_range(99) < 25) f = cfg_src;
      if ($urandom_range(99) < 25) t = cfg_snk;
      case ($urandom_range(0, 4))
        0: c = 32'd0;
        1: c = $urandom;
        default: c = $urandom_range(1, 1000);
      endcase
      send_edge(f, t, c, i == count-1);
    end
  endtask

  task automatic random_config();
    logic [7:0] n;
    int ne;
    case ($urandom_range(0, 9))
      0: n = 8'd0;
      1: n = 8'd1;
      2: n = 8'd128;
      3: n = 8'($urandom_range(0, 255));
      default: n = 8'($urandom_range(2, 16));
    endcase
    ne = (n < 2) ? 2 : (n > NODES) ? NODES : int'(n);
    if ($urandom_range(99) < 15)
      set_config(n, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    else
      set_config(n, 7'($urandom_range(0, ne-1)), 7'($urandom_range(0, ne-1)));
  endtask

  typedef struct {
    logic [6:0]  f;
    logic [6:0]  t;
    logic [31:0] c;
    logic        l;
    bit          typed;
    logic [47:0] flow;
  } edge_row_t;

  // directed rows at reset configuration (128 nodes, source 0, sink 1)
  edge_row_t dir_rows [16] = '{
    '{7'd0,   7'd1,   32'd5,         1'b1, 1'b1, 48'd5},
    '{7'd0,   7'd2,   32'd10,        1'b0, 1'b0, 48'd0},
    '{7'd2,   7'd1,   32'd7,         1'b0, 1'b0, 48'd0},
    '{7'd0,   7'd1,   32'd3,         1'b1, 1'b1, 48'd10},
    '{7'd0,   7'd0,   32'hFFFFFFFF,  1'b0, 1'b0, 48'd0},
    '{7'd1,   7'd1,   32'hFFFFFFFF,  1'b0, 1'b0, 48'd0},
    '{7'd0,   7'd1,   32'd0,         1'b1, 1'b1, 48'd0},
    '{7'd0,   7'd1,   32'hFFFFFFFF,  1'b0, 1'b0, 48'd0},
    '{7'd0,   7'd1,   32'hFFFFFFFF,  1'b1, 1'b1, 48'h1FFFFFFFE},
    '{7'd127, 7'd1,   32'hFFFFFFFF,  1'b0, 1'b0, 48'd0},
    '{7'd0,   7'd127, 32'hFFFFFFFF,  1'b1, 1'b1, 48'hFFFFFFFF},
    '{7'd1,   7'd0,   32'd9,         1'b0, 1'b0, 48'd0},
    '{7'd0,   7'd3,   32'd4,         1'b0, 1'b0, 48'd0},
    '{7'd3,   7'd4,   32'd6,         1'b0, 1'b0, 48'd0},
    '{7'd4,   7'd1,   32'd2,         1'b0, 1'b0, 48'd0},
    '{7'd3,   7'd1,   32'd1,         1'b1, 1'b0, 48'd0}
  };

  initial begin
    int budget;
    int n_rand;
    for (int i = 0; i < NODES*NODES; i++) cells[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_rows[i]) begin
      use_typed = dir_rows[i].typed;
      typed_flow = dir_rows[i].flow;
      send_edge(dir_rows[i].f, dir_rows[i].t, dir_rows[i].c, dir_rows[i].l);
    end
    drain();
    use_typed = 0;
    // clamped node counts, equal endpoints and an out-of-range sink
    set_config(8'd0, 7'd0, 7'd1);
    send_edge(7'd0, 7'd1, 32'd77, 1'b0);
    send_edge(7'd5, 7'd1, 32'd8, 1'b1);
    set_config(8'd255, 7'd127, 7'd1);
    send_edge(7'd127, 7'd1, 32'd50, 1'b1);
    set_config(8'd4, 7'd2, 7'd2);
    send_edge(7'd2, 7'd2, 32'd50, 1'b1);
    set_config(8'd3, 7'd0, 7'd3);
    send_edge(7'd0, 7'd3, 32'd50, 1'b1);

    // cell saturation: repeated full capacities on one pair
    set_config(8'd2, 7'd0, 7'd1);
    for (int i = 0; i < 260; i++) send_edge(7'd0, 7'd1, 32'hFFFFFFFF, i == 259);

    // random part in three phases with different sender idling
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 27 : (ph == 1) ? 45 : 0;
      drain();
      budget = 400;
      while (budget > 0) begin
        if ($urandom_range(0, 3) == 0) random_config();
        n_rand = $urandom_range(5, 50);
        if (eff_nodes() > 32) n_rand = $urandom_range(1, 12);
        random_graph(n_rand);
        budget -= n_rand;
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (flow_q.size() != 0) begin
      $display("%0d totals never arrived", flow_q.size());
      errors++;
    end
    $display("Covered %0d edges and %0d max-flow totals over varied node counts,",
             edges_sent, totals_seen);
    $display("endpoints, saturating cells and sender gaps; %0d mismatches.", errors);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #500000000;
    $display("timeout waiting for the block");
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
rtl/mfb_pkg.sv
rtl/mfb_alu.sv
rtl/max_flow_bfs_augment.sv
sim/tb_top.sv
